/* rtl/cascu_pkg.sv */
// cascu_pkg: types and constants shared by the clock/alarm/stopwatch mode controller
// no dependencies; used by the interfaces, the update logic, the top level and the checker
`timescale 1ns / 1ps

package cascu_pkg;

    // event codes
    typedef enum logic [2:0] {
        CMD_MODE_SHORT  = 3'd0,
        CMD_START_SHORT = 3'd1,
        CMD_LIGHT_SHORT = 3'd2,
        CMD_MODE_HOLD1  = 3'd3,
        CMD_MODE_HOLD2  = 3'd4,
        CMD_MODE_HOLD3  = 3'd5,
        CMD_SEC_TICK    = 3'd6,
        CMD_POLL        = 3'd7
    } t_cmd;

    // operating modes
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ADJUST = 2'd1,
        MODE_ALARM  = 2'd2,
        MODE_SW     = 2'd3
    } t_mode;

    // clock field codes
    localparam logic [2:0] FLD_DATE   = 3'd0;
    localparam logic [2:0] FLD_MONTH  = 3'd1;
    localparam logic [2:0] FLD_YEAR   = 3'd2;
    localparam logic [2:0] FLD_HOUR   = 3'd3;
    localparam logic [2:0] FLD_MINUTE = 3'd4;
    localparam logic [2:0] FLD_SECOND = 3'd5;

    // alarm field codes
    localparam logic [1:0] AF_HOUR   = 2'd0;
    localparam logic [1:0] AF_MINUTE = 2'd1;
    localparam logic [1:0] AF_SECOND = 2'd2;

    // blink interval after reset
    localparam logic [15:0] BLINK_RESET_MS = 16'd500;

    // input event payload
    typedef struct packed {
        logic [2:0]  command;
        logic [4:0]  rtc_date;
        logic [3:0]  rtc_month;
        logic [6:0]  rtc_year;
        logic [4:0]  rtc_hour;
        logic [5:0]  rtc_minute;
        logic [5:0]  rtc_second;
        logic [9:0]  sub_count;
        logic [31:0] ms_now;
    } t_evt;

    // result payload
    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] selected_field;
        logic       rtc_write;
        logic [2:0] rtc_write_field;
        logic [6:0] rtc_write_value;
        logic       backlight;
        logic       alarm_armed;
        logic       alarm_ringing;
        logic       stopwatch_running;
        logic [7:0] stopwatch_minutes;
        logic [5:0] stopwatch_seconds;
        logic [6:0] stopwatch_hundredths;
    } t_res;

    // controller state
    typedef struct packed {
        t_mode       mode;
        logic [2:0]  adjust_field;
        logic [1:0]  alarm_field;
        logic [4:0]  alarm_hour;
        logic [5:0]  alarm_minute;
        logic [5:0]  alarm_second;
        logic        armed;
        logic        ringing;
        logic        light;
        logic        run_req;
        logic        tick_en;
        logic [7:0]  sw_minutes;
        logic [5:0]  sw_seconds;
        logic [6:0]  sw_hundredths;
        logic [31:0] last_toggle_ms;
    } t_state;

endpackage

/* rtl/cascu_if.sv */
// cascu_if: valid/ready channel interfaces for events, results and configuration
// depends on cascu_pkg for the payload types
`timescale 1ns / 1ps

// event channel
interface cascu_evt_if import cascu_pkg::*; ();
    logic valid;
    logic ready;
    t_evt data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface cascu_res_if import cascu_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// configuration write channel, blink interval only
interface cascu_cfg_if import cascu_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/cascu_update.sv */
// cascu_update: next-state and result logic for one event, purely combinational
// depends on cascu_pkg for state, event and result types
`timescale 1ns / 1ps

module cascu_update import cascu_pkg::*; (
    input  t_state      i_state,
    input  t_evt        i_evt,
    input  logic [15:0] i_blink_ms,
    output t_state      o_state,
    output t_res        o_res
);

    logic [4:0]  date_nx;
    logic [3:0]  month_nx;
    logic [7:0]  year_p1;
    logic [6:0]  year_nx;
    logic [5:0]  hour_p1;
    logic [4:0]  hour_nx;
    logic [6:0]  min_p1;
    logic [5:0]  min_nx;
    logic [6:0]  sec_p1;
    logic [5:0]  sec_nx;
    logic [5:0]  ahour_p1;
    logic [6:0]  amin_p1;
    logic [6:0]  asec_p1;
    logic [17:0] hund_prod;
    logic [6:0]  hund_raw;
    logic [6:0]  hund_sat;
    logic [6:0]  swsec_p1;
    logic [31:0] elapsed;
    logic        blink_due;
    logic        alarm_match;
    logic        wr;
    logic [2:0]  wf;
    logic [6:0]  wv;
    logic [2:0]  sel;
    t_state      n;

    // clock field increments with wrap
    always_comb begin
        date_nx  = (i_evt.rtc_date == 5'd31) ? 5'd1 : i_evt.rtc_date + 5'd1;
        month_nx = (i_evt.rtc_month >= 4'd12) ? i_evt.rtc_month - 4'd11
                                              : i_evt.rtc_month + 4'd1;
        year_p1  = {1'b0, i_evt.rtc_year} + 8'd1;
        year_nx  = (year_p1 >= 8'd100) ? 7'(year_p1 - 8'd100) : year_p1[6:0];
        hour_p1  = {1'b0, i_evt.rtc_hour} + 6'd1;
        hour_nx  = (hour_p1 >= 6'd24) ? 5'(hour_p1 - 6'd24) : hour_p1[4:0];
        min_p1   = {1'b0, i_evt.rtc_minute} + 7'd1;
        min_nx   = (min_p1 >= 7'd60) ? 6'(min_p1 - 7'd60) : min_p1[5:0];
        sec_p1   = {1'b0, i_evt.rtc_second} + 7'd1;
        sec_nx   = (sec_p1 >= 7'd60) ? 6'(sec_p1 - 7'd60) : sec_p1[5:0];
    end

    // alarm, stopwatch and blink helpers
    always_comb begin
        ahour_p1    = {1'b0, i_state.alarm_hour} + 6'd1;
        amin_p1     = {1'b0, i_state.alarm_minute} + 7'd1;
        asec_p1     = {1'b0, i_state.alarm_second} + 7'd1;
        // divide by ten as multiply by 205 and shift by 11, exact below 1024
        hund_prod   = 18'(i_evt.sub_count) * 18'd205;
        hund_raw    = hund_prod[17:11];
        hund_sat    = (hund_raw > 7'd99) ? 7'd99 : hund_raw;
        swsec_p1    = {1'b0, i_state.sw_seconds} + 7'd1;
        elapsed     = i_evt.ms_now - i_state.last_toggle_ms;
        blink_due   = elapsed >= {16'd0, i_blink_ms};
        alarm_match = i_state.armed
                   && (i_evt.rtc_hour == i_state.alarm_hour)
                   && (i_evt.rtc_minute == i_state.alarm_minute)
                   && (i_evt.rtc_second == i_state.alarm_second);
    end

    // event decode and state update
    always_comb begin
        n  = i_state;
        wr = 1'b0;
        wf = FLD_DATE;
        wv = 7'd0;
        unique case (t_cmd'(i_evt.command))
            CMD_MODE_SHORT: begin
                if (i_state.mode == MODE_ALARM) n.armed = 1'b1;
                n.mode = MODE_IDLE;
            end
            CMD_START_SHORT: begin
                unique case (i_state.mode)
                    MODE_ADJUST: begin
                        wr = (i_state.adjust_field <= FLD_SECOND);
                        wf = wr ? i_state.adjust_field : FLD_DATE;
                        priority case (i_state.adjust_field)
                            FLD_DATE:   wv = {2'd0, date_nx};
                            FLD_MONTH:  wv = {3'd0, month_nx};
                            FLD_YEAR:   wv = year_nx;
                            FLD_HOUR:   wv = {2'd0, hour_nx};
                            FLD_MINUTE: wv = {1'b0, min_nx};
                            FLD_SECOND: wv = {1'b0, sec_nx};
                            default:    wv = 7'd0;
                        endcase
                    end
                    MODE_ALARM: begin
                        priority case (i_state.alarm_field)
                            AF_HOUR: n.alarm_hour = (ahour_p1 >= 6'd24) ? 5'd0
                                                                        : ahour_p1[4:0];
                            AF_MINUTE: n.alarm_minute = (amin_p1 >= 7'd60) ? 6'd0
                                                                           : amin_p1[5:0];
                            AF_SECOND: n.alarm_second = (asec_p1 >= 7'd60) ? 6'd0
                                                                           : asec_p1[5:0];
                            default: ;
                        endcase
                    end
                    MODE_SW:   n.run_req = ~i_state.run_req;
                    MODE_IDLE: ;
                endcase
            end
            CMD_LIGHT_SHORT: begin
                // a press while ringing acknowledges and disarms
                if (i_state.ringing) begin
                    n.armed   = 1'b0;
                    n.ringing = 1'b0;
                end
                unique case (i_state.mode)
                    MODE_IDLE: n.light = ~i_state.light;
                    MODE_ADJUST: begin
                        if (i_state.adjust_field < FLD_SECOND) begin
                            n.adjust_field = i_state.adjust_field + 3'd1;
                        end else if (i_state.adjust_field == FLD_SECOND) begin
                            n.adjust_field = FLD_DATE;
                        end
                    end
                    MODE_ALARM: begin
                        priority case (i_state.alarm_field)
                            AF_SECOND: n.alarm_field = AF_MINUTE;
                            AF_MINUTE: n.alarm_field = AF_HOUR;
                            AF_HOUR:   n.alarm_field = AF_SECOND;
                            default: ;
                        endcase
                    end
                    MODE_SW: begin
                        n.sw_minutes    = 8'd0;
                        n.sw_seconds    = 6'd0;
                        n.sw_hundredths = 7'd0;
                    end
                endcase
            end
            CMD_MODE_HOLD1: begin
                if (i_state.mode == MODE_IDLE) begin
                    n.mode         = MODE_ADJUST;
                    n.adjust_field = FLD_DATE;
                end
            end
            CMD_MODE_HOLD2: begin
                if (i_state.mode == MODE_ADJUST) begin
                    n.mode         = MODE_ALARM;
                    n.alarm_field  = AF_SECOND;
                    n.alarm_hour   = 5'd0;
                    n.alarm_minute = 6'd0;
                    n.alarm_second = 6'd0;
                end
            end
            CMD_MODE_HOLD3: begin
                if (i_state.mode == MODE_ALARM) begin
                    n.mode    = MODE_SW;
                    n.run_req = 1'b0;
                end
            end
            CMD_SEC_TICK: begin
                if (i_state.tick_en) begin
                    if (swsec_p1 >= 7'd60) begin
                        n.sw_seconds = 6'd0;
                        n.sw_minutes = i_state.sw_minutes + 8'd1;
                    end else begin
                        n.sw_seconds = swsec_p1[5:0];
                    end
                end
            end
            CMD_POLL: begin
                if (i_state.mode == MODE_SW) begin
                    if (i_state.run_req) begin
                        n.sw_hundredths = hund_sat;
                        n.tick_en       = 1'b1;
                    end else begin
                        n.tick_en = 1'b0;
                    end
                end
                if (alarm_match) n.ringing = 1'b1;
                // blink while ringing, including a match on this poll
                if (n.ringing && blink_due) begin
                    n.light          = ~i_state.light;
                    n.last_toggle_ms = i_evt.ms_now;
                end
            end
        endcase
    end

    // selected field as shown after the update
    always_comb begin
        sel = FLD_DATE;
        if (n.mode == MODE_ADJUST) begin
            sel = n.adjust_field;
        end else if (n.mode == MODE_ALARM && n.alarm_field <= AF_SECOND) begin
            sel = {1'b0, n.alarm_field} + FLD_HOUR;
        end
    end

    // result assembly
    always_comb begin
        o_state                    = n;
        o_res.mode                 = n.mode;
        o_res.selected_field       = sel;
        o_res.rtc_write            = wr;
        o_res.rtc_write_field      = wf;
        o_res.rtc_write_value      = wv;
        o_res.backlight            = n.light;
        o_res.alarm_armed          = n.armed;
        o_res.alarm_ringing        = n.ringing;
        o_res.stopwatch_running    = n.tick_en;
        o_res.stopwatch_minutes    = n.sw_minutes;
        o_res.stopwatch_seconds    = n.sw_seconds;
        o_res.stopwatch_hundredths = n.sw_hundredths;
    end

endmodule

/* rtl/clock_alarm_stopwatch_mode_control_unit.sv */
// clock_alarm_stopwatch_mode_control_unit: mode controller for a clock with alarm and stopwatch
// depends on cascu_pkg, the channel interfaces in cascu_if and cascu_update
`timescale 1ns / 1ps

// usage
// i_evt carries one event per transaction: a button press or hold, a second tick
// or a poll with the current clock time, stopwatch sub-count and millisecond time.
// o_res returns exactly one result transaction per event, in order: mode, selected
// field, an optional clock field write, backlight, alarm flags and stopwatch count.
// i_cfg writes the blink interval in milliseconds; it is always ready. The user must
// write it only while no event is in flight; the block does not enforce this.
// an accepted event waits in the event register, and its update result is
// registered into the result register as the event leaves the event register.
// throughput: one event per cycle while o_res is not stalled; the event register and
// the result register are separate, with the full update done in one pass between them.
// when o_res is stalled the result holds and i_evt keeps taking one more event
// into the event register, then drops ready until the result is taken.
// reset (i_rst_n low, synchronous) empties both registers, sets idle mode, armed
// alarm at 00:00:00, backlight off, stopwatch cleared and the interval to 500 ms.

module clock_alarm_stopwatch_mode_control_unit import cascu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cascu_evt_if.sink        i_evt,
    cascu_res_if.source      o_res,
    cascu_cfg_if.sink        i_cfg
);

    logic        r_evt_valid;
    t_evt        r_evt;
    logic        r_res_valid;
    t_res        r_res;
    t_state      r_state;
    t_state      n_state;
    t_res        n_res;
    logic [15:0] r_blink_ms;
    logic        advance;

    // pipeline flow control
    assign advance     = r_evt_valid && (!r_res_valid || o_res.ready);
    assign i_evt.ready = !r_evt_valid || advance;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    // event register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_evt_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) r_evt <= i_evt.data;
    end

    // update logic
    cascu_update u_update (
        .i_state    (r_state),
        .i_evt      (r_evt),
        .i_blink_ms (r_blink_ms),
        .o_state    (n_state),
        .o_res      (n_res)
    );

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: MODE_IDLE, adjust_field: FLD_DATE, alarm_field: AF_HOUR,
                         armed: 1'b1, default: '0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // blink interval register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_ms <= BLINK_RESET_MS;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_blink_ms <= i_cfg.data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (advance) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_res <= n_res;
    end

endmodule

/* rtl/cascu_checker.sv */
// cascu_checker: port-level assertions for the mode controller, bound to the top level
// depends on cascu_pkg and on the top level's ports
`timescale 1ns / 1ps

module cascu_checker import cascu_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_res_valid,
    input logic i_res_ready,
    input t_res i_res_data
);

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // a stalled result holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("stalled result changed");

    // clock writes only from adjust mode, on the selected field
    a_write_adjust: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.rtc_write |->
            i_res_data.mode == MODE_ADJUST
            && i_res_data.rtc_write_field == i_res_data.selected_field)
        else $error("clock write outside adjust mode");

    // idle write fields are zero
    a_write_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_data.rtc_write |->
            i_res_data.rtc_write_field == FLD_DATE && i_res_data.rtc_write_value == 7'd0)
        else $error("write fields set without a write");

    // ringing needs an armed alarm, stopwatch counts stay in range
    a_flag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |->
            (!i_res_data.alarm_ringing || i_res_data.alarm_armed)
            && i_res_data.stopwatch_seconds < 6'd60
            && i_res_data.stopwatch_hundredths < 7'd100)
        else $error("alarm flags or stopwatch count out of range");

endmodule

bind clock_alarm_stopwatch_mode_control_unit cascu_checker u_cascu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);

/* verif/cascu_tb_pkg.sv */
// cascu_tb_pkg: scoreboard for the clock/alarm/stopwatch mode controller testbench
// depends on cascu_pkg for the event, result, mode and field types
`timescale 1ns / 1ps

package cascu_tb_pkg;
    import cascu_pkg::*;

    class cascu_scoreboard;
        // predicted controller state
        t_mode       mode;
        logic [2:0]  adj_fld;
        logic [1:0]  alm_fld;
        logic [4:0]  alm_hour;
        logic [5:0]  alm_min;
        logic [5:0]  alm_sec;
        bit          armed;
        bit          ringing;
        bit          light;
        bit          run_req;
        bit          tick_en;
        logic [7:0]  sw_min;
        logic [5:0]  sw_sec;
        logic [6:0]  sw_hund;
        logic [31:0] last_toggle;
        logic [15:0] blink_ms;

        // results predicted but not yet returned, oldest first
        t_res        pending_results[$];
        int          errors;
        int          n_results;

        function new();
            mode        = MODE_IDLE;
            adj_fld     = FLD_DATE;
            alm_fld     = AF_HOUR;
            alm_hour    = '0;
            alm_min     = '0;
            alm_sec     = '0;
            armed       = 1'b1;
            ringing     = 1'b0;
            light       = 1'b0;
            run_req     = 1'b0;
            tick_en     = 1'b0;
            sw_min      = '0;
            sw_sec      = '0;
            sw_hund     = '0;
            last_toggle = '0;
            blink_ms    = BLINK_RESET_MS;
            errors      = 0;
            n_results   = 0;
        endfunction

        function void set_interval(logic [15:0] ms);
            blink_ms = ms;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // advance the controller by one accepted event and queue its result
        function void note_event(t_evt e);
            t_res        r;
            int          v;
            int          hund;
            logic [31:0] elapsed;
            r = '0;
            case (e.command)
                CMD_MODE_SHORT: begin
                    if (mode == MODE_ALARM) armed = 1'b1;
                    mode = MODE_IDLE;
                end
                CMD_START_SHORT: begin
                    if (mode == MODE_ADJUST && adj_fld <= FLD_SECOND) begin
                        case (adj_fld)
                            FLD_DATE:   v = int'(e.rtc_date) % 31 + 1;
                            FLD_MONTH:  v = int'(e.rtc_month) % 12 + 1;
                            FLD_YEAR:   v = (int'(e.rtc_year) + 1) % 100;
                            FLD_HOUR:   v = (int'(e.rtc_hour) + 1) % 24;
                            FLD_MINUTE: v = (int'(e.rtc_minute) + 1) % 60;
                            default:    v = (int'(e.rtc_second) + 1) % 60;
                        endcase
                        r.rtc_write       = 1'b1;
                        r.rtc_write_field = adj_fld;
                        r.rtc_write_value = 7'(v);
                    end else if (mode == MODE_ALARM) begin
                        case (alm_fld)
                            AF_HOUR:   alm_hour = 5'((int'(alm_hour) + 1) % 24);
                            AF_MINUTE: alm_min  = 6'((int'(alm_min) + 1) % 60);
                            AF_SECOND: alm_sec  = 6'((int'(alm_sec) + 1) % 60);
                            default: ;
                        endcase
                    end else if (mode == MODE_SW) begin
                        run_req = ~run_req;
                    end
                end
                CMD_LIGHT_SHORT: begin
                    // acknowledging a ringing alarm also disarms it
                    if (ringing) begin
                        armed   = 1'b0;
                        ringing = 1'b0;
                    end
                    case (mode)
                        MODE_IDLE: light = ~light;
                        MODE_ADJUST: begin
                            if (adj_fld < FLD_SECOND) adj_fld = adj_fld + 3'd1;
                            else if (adj_fld == FLD_SECOND) adj_fld = FLD_DATE;
                        end
                        MODE_ALARM: begin
                            case (alm_fld)
                                AF_SECOND: alm_fld = AF_MINUTE;
                                AF_MINUTE: alm_fld = AF_HOUR;
                                AF_HOUR:   alm_fld = AF_SECOND;
                                default: ;
                            endcase
                        end
                        default: begin
                            sw_min  = '0;
                            sw_sec  = '0;
                            sw_hund = '0;
                        end
                    endcase
                end
                CMD_MODE_HOLD1: begin
                    if (mode == MODE_IDLE) begin
                        mode    = MODE_ADJUST;
                        adj_fld = FLD_DATE;
                    end
                end
                CMD_MODE_HOLD2: begin
                    if (mode == MODE_ADJUST) begin
                        mode     = MODE_ALARM;
                        alm_fld  = AF_SECOND;
                        alm_hour = '0;
                        alm_min  = '0;
                        alm_sec  = '0;
                    end
                end
                CMD_MODE_HOLD3: begin
                    if (mode == MODE_ALARM) begin
                        mode    = MODE_SW;
                        run_req = 1'b0;
                    end
                end
                CMD_SEC_TICK: begin
                    if (tick_en) begin
                        if (sw_sec >= 6'd59) begin
                            sw_sec = '0;
                            sw_min = sw_min + 8'd1;
                        end else begin
                            sw_sec = sw_sec + 6'd1;
                        end
                    end
                end
                default: begin
                    // poll: stopwatch sampling, alarm compare, blink
                    if (mode == MODE_SW) begin
                        if (run_req) begin
                            hund    = int'(e.sub_count) / 10;
                            sw_hund = (hund > 99) ? 7'd99 : 7'(hund);
                            tick_en = 1'b1;
                        end else begin
                            tick_en = 1'b0;
                        end
                    end
                    if (armed && e.rtc_hour == alm_hour && e.rtc_minute == alm_min &&
                        e.rtc_second == alm_sec)
                        ringing = 1'b1;
                    elapsed = e.ms_now - last_toggle;
                    if (ringing && elapsed >= {16'd0, blink_ms}) begin
                        light       = ~light;
                        last_toggle = e.ms_now;
                    end
                end
            endcase

            if (mode == MODE_ADJUST) r.selected_field = adj_fld;
            else if (mode == MODE_ALARM && alm_fld <= AF_SECOND)
                r.selected_field = 3'(alm_fld) + 3'd3;
            r.mode                 = mode;
            r.backlight            = light;
            r.alarm_armed          = armed;
            r.alarm_ringing        = ringing;
            r.stopwatch_running    = tick_en;
            r.stopwatch_minutes    = sw_min;
            r.stopwatch_seconds    = sw_sec;
            r.stopwatch_hundredths = sw_hund;
            pending_results.push_back(r);
        endfunction

        task report(string what);
            $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        task cmp_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0d expected %0d",
                                 n_results, name, got, want));
        endtask

        // compare one returned result with the oldest prediction
        task check_result(t_res got);
            t_res want;
            if (pending_results.size() == 0) begin
                report("result transaction with no event outstanding");
                return;
            end
            want = pending_results.pop_front();
            cmp_field("mode", got.mode, want.mode);
            cmp_field("selected_field", got.selected_field, want.selected_field);
            cmp_field("rtc_write", got.rtc_write, want.rtc_write);
            cmp_field("rtc_write_field", got.rtc_write_field, want.rtc_write_field);
            cmp_field("rtc_write_value", got.rtc_write_value, want.rtc_write_value);
            cmp_field("backlight", got.backlight, want.backlight);
            cmp_field("alarm_armed", got.alarm_armed, want.alarm_armed);
            cmp_field("alarm_ringing", got.alarm_ringing, want.alarm_ringing);
            cmp_field("stopwatch_running", got.stopwatch_running, want.stopwatch_running);
            cmp_field("stopwatch_minutes", got.stopwatch_minutes, want.stopwatch_minutes);
            cmp_field("stopwatch_seconds", got.stopwatch_seconds, want.stopwatch_seconds);
            cmp_field("stopwatch_hundredths", got.stopwatch_hundredths,
                      want.stopwatch_hundredths);
            n_results++;
        endtask
    endclass

endpackage

/* verif/tb_top.sv */
// tb_top: drives events and blink-interval writes into the mode controller and checks
// every result against the scoreboard; depends on cascu_pkg, cascu_if and cascu_tb_pkg
`timescale 1ns / 1ps

module tb_top;
    import cascu_pkg::*;
    import cascu_tb_pkg::*;

    localparam int HALF_PERIOD_NS = 6;
    localparam int STALL_LIMIT    = 2000;
    localparam int PHASE_ITEMS    = 200;
    localparam int N_PHASES       = 6;
    localparam t_cmd NAV_CMDS [4] = '{CMD_MODE_SHORT, CMD_MODE_HOLD1,
                                      CMD_MODE_HOLD2, CMD_MODE_HOLD3};

    logic            i_clk;
    logic            i_rst_n;
    cascu_scoreboard sb;
    logic [31:0]     ms_clock;
    bit              bursts_on;
    bit              last_part;
    int              accepted;
    int              quiet_cycles;

    cascu_evt_if evt_ch ();
    cascu_res_if res_ch ();
    cascu_cfg_if cfg_ch ();

    clock_alarm_stopwatch_mode_control_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #HALF_PERIOD_NS;
        i_clk = 1'b1;
        #HALF_PERIOD_NS;
    end

    // build an event; wild fields cover every bit, otherwise fields stay in range
    function automatic t_evt make_event(t_cmd cmd, bit wild);
        t_evt e;
        e.command = cmd;
        if (wild) begin
            e.rtc_date   = 5'($urandom_range(0, 31));
            e.rtc_month  = 4'($urandom_range(0, 15));
            e.rtc_year   = 7'($urandom_range(0, 127));
            e.rtc_hour   = 5'($urandom_range(0, 31));
            e.rtc_minute = 6'($urandom_range(0, 63));
            e.rtc_second = 6'($urandom_range(0, 63));
            e.sub_count  = 10'($urandom_range(0, 1023));
        end else begin
            e.rtc_date   = 5'($urandom_range(1, 31));
            e.rtc_month  = 4'($urandom_range(1, 12));
            e.rtc_year   = 7'($urandom_range(0, 99));
            e.rtc_hour   = 5'($urandom_range(0, 23));
            e.rtc_minute = 6'($urandom_range(0, 59));
            e.rtc_second = 6'($urandom_range(0, 59));
            e.sub_count  = 10'($urandom_range(0, 999));
        end
        // millisecond time mostly creeps forward around the blink interval
        if ($urandom_range(0, 19) == 0) ms_clock = $urandom();
        else ms_clock = ms_clock + $urandom_range(0, 2 * int'(sb.blink_ms) + 2);
        e.ms_now = ms_clock;
        return e;
    endfunction

    // one event transaction; called and returns at a falling edge
    task automatic send_event(t_evt e);
        if (bursts_on && $urandom_range(0, 7) == 0) begin
            evt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        evt_ch.valid <= 1'b1;
        evt_ch.data  <= e;
        do @(posedge i_clk); while (!evt_ch.ready);
        sb.note_event(e);
        accepted++;
        @(negedge i_clk);
    endtask

    task automatic send_cmd(t_cmd cmd);
        send_event(make_event(cmd, $urandom_range(0, 15) == 0));
    endtask

    // poll whose clock time equals the current alarm time
    task automatic send_alarm_poll();
        t_evt e;
        e = make_event(CMD_POLL, 1'b0);
        e.rtc_hour   = sb.alm_hour;
        e.rtc_minute = sb.alm_min;
        e.rtc_second = sb.alm_sec;
        send_event(e);
    endtask

    // hold off events until every outstanding result has returned
    task automatic drain_results();
        evt_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_interval(logic [15:0] ms);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= ms;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_interval(ms);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic directed_events();
        t_evt e;
        // poll with every field at its top value, hour 31 can never match
        e = '1;
        e.command = CMD_POLL;
        send_event(e);
        // 00:00:00 matches the armed alarm straight out of reset
        e = '0;
        e.command = CMD_POLL;
        send_event(e);
        // exactly one interval later the backlight toggles
        e.ms_now = {16'd0, BLINK_RESET_MS};
        send_event(e);
        send_cmd(CMD_LIGHT_SHORT);
        send_cmd(CMD_MODE_HOLD1);
        // every adjust field at or beyond its range, last light wraps to date
        for (int f = 0; f < 6; f++) begin
            e = make_event(CMD_START_SHORT, 1'b0);
            case (f)
                0: e.rtc_date   = 5'd31;
                1: e.rtc_month  = 4'd15;
                2: e.rtc_year   = 7'd127;
                3: e.rtc_hour   = 5'd31;
                4: e.rtc_minute = 6'd63;
                default: e.rtc_second = 6'd59;
            endcase
            send_event(e);
            send_cmd(CMD_LIGHT_SHORT);
        end
        // alarm edit: second, then minute, then hour
        send_cmd(CMD_MODE_HOLD2);
        send_cmd(CMD_START_SHORT);
        send_cmd(CMD_LIGHT_SHORT);
        send_cmd(CMD_LIGHT_SHORT);
        send_cmd(CMD_START_SHORT);
        send_cmd(CMD_MODE_SHORT);
        send_alarm_poll();
        send_cmd(CMD_LIGHT_SHORT);
        // stopwatch: run, saturated hundredths, tick, clear, pause
        send_cmd(CMD_MODE_HOLD1);
        send_cmd(CMD_MODE_HOLD2);
        send_cmd(CMD_MODE_HOLD3);
        send_cmd(CMD_START_SHORT);
        e = make_event(CMD_POLL, 1'b0);
        e.sub_count = 10'd1023;
        send_event(e);
        send_cmd(CMD_SEC_TICK);
        send_cmd(CMD_LIGHT_SHORT);
        send_cmd(CMD_START_SHORT);
        send_cmd(CMD_POLL);
        send_cmd(CMD_MODE_SHORT);
    endtask

    // set an alarm, usually arm it, then poll so that it may ring and blink
    task automatic alarm_sequence();
        int n;
        send_cmd(CMD_MODE_SHORT);
        send_cmd(CMD_MODE_HOLD1);
        send_cmd(CMD_MODE_HOLD2);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
        repeat (n) send_cmd($urandom_range(0, 2) != 0 ? CMD_START_SHORT : CMD_LIGHT_SHORT);
        if ($urandom_range(0, 4) != 0) send_cmd(CMD_MODE_SHORT);
        if ($urandom_range(0, 3) != 0) send_alarm_poll();
        repeat ($urandom_range(2, 15)) begin
            case ($urandom_range(0, 5))
                0: send_alarm_poll();
                1: send_cmd(t_cmd'($urandom_range(0, 6)));
                default: send_cmd(CMD_POLL);
            endcase
        end
        if ($urandom_range(0, 3) != 0) send_cmd(CMD_LIGHT_SHORT);
    endtask

    task automatic stopwatch_sequence();
        int n;
        int pick;
        send_cmd(CMD_MODE_SHORT);
        send_cmd(CMD_MODE_HOLD1);
        send_cmd(CMD_MODE_HOLD2);
        send_cmd(CMD_MODE_HOLD3);
        send_cmd(CMD_START_SHORT);
        send_cmd(CMD_POLL);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150) : $urandom_range(3, 20);
        repeat (n) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) send_cmd(CMD_START_SHORT);
            else if (pick == 1) send_cmd(CMD_LIGHT_SHORT);
            else if (pick < 4) send_cmd(CMD_POLL);
            else send_cmd(CMD_SEC_TICK);
        end
        // ticks keep counting after leaving the mode while running
        if ($urandom_range(0, 2) == 0) begin
            send_cmd(CMD_MODE_SHORT);
            repeat ($urandom_range(1, 8)) send_cmd(CMD_SEC_TICK);
        end
    endtask

    task automatic adjust_sequence();
        send_cmd(CMD_MODE_SHORT);
        send_cmd(CMD_MODE_HOLD1);
        repeat ($urandom_range(1, 20)) begin
            case ($urandom_range(0, 4))
                0, 1: send_cmd(CMD_START_SHORT);
                2, 3: send_cmd(CMD_LIGHT_SHORT);
                default: send_cmd(CMD_POLL);
            endcase
        end
    endtask

    task automatic run_phase(int n_items);
        int target;
        int pick;
        target = accepted + n_items;
        while (accepted < target) begin
            bursts_on = !last_part && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 3) alarm_sequence();
            else if (pick < 6) stopwatch_sequence();
            else if (pick < 8) adjust_sequence();
            else if (pick == 8) begin
                repeat ($urandom_range(1, 10))
                    send_event(make_event(t_cmd'($urandom_range(0, 7)), 1'b1));
            end else begin
                repeat ($urandom_range(1, 6)) send_cmd(NAV_CMDS[$urandom_range(0, 3)]);
            end
        end
    endtask

    // stimulus
    initial begin
        logic [15:0] intervals [N_PHASES];
        sb           = new();
        ms_clock     = '0;
        bursts_on    = 1'b1;
        last_part    = 1'b0;
        accepted     = 0;
        i_rst_n      = 1'b0;
        evt_ch.valid = 1'b0;
        evt_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        intervals    = '{16'd65535, 16'd1, 16'd0, 16'($urandom_range(2, 1000)),
                         16'($urandom_range(0, 65535)), BLINK_RESET_MS};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_events();
        for (int p = 0; p < N_PHASES; p++) begin
            write_interval(intervals[p]);
            last_part = (p == N_PHASES - 1);
            run_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // result ready with random stall bursts
    initial begin
        int stall;
        stall = 0;
        res_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall == 0 && bursts_on && $urandom_range(0, 9) == 0)
                stall = $urandom_range(1, 14);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // check each result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
    end

    // watchdog on cycles without any transaction
    initial quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, sb.outstanding());
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
